@@ hdl/assert_macros.svh @@
// Assertion macros used by vzb_checker.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VZB_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define VZB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/vzb_pkg.sv @@
// Types and constants of the voxel z-buffer visibility block.
// No dependencies; used by the top level, vzb_front and vzb_back.
`default_nettype none

package vzb_pkg;

	// Input function codes
	localparam logic [1:0] FUNC_POSE  = 2'd0;
	localparam logic [1:0] FUNC_DEPTH = 2'd1;
	localparam logic [1:0] FUNC_VIS   = 2'd2;

	// Configuration register indexes
	localparam logic [2:0] REG_FOCAL_X   = 3'd0;
	localparam logic [2:0] REG_FOCAL_Y   = 3'd1;
	localparam logic [2:0] REG_CENTER_X  = 3'd2;
	localparam logic [2:0] REG_CENTER_Y  = 3'd3;
	localparam logic [2:0] REG_WIDTH     = 3'd4;
	localparam logic [2:0] REG_HEIGHT    = 3'd5;
	localparam logic [2:0] REG_DOWNSCALE = 3'd6;
	localparam logic [2:0] REG_TOLERANCE = 3'd7;

	// Register reset values
	localparam logic [31:0] RST_FOCAL_X   = 32'd32768000;
	localparam logic [31:0] RST_FOCAL_Y   = 32'd32768000;
	localparam logic [31:0] RST_CENTER_X  = 32'd20971520;
	localparam logic [31:0] RST_CENTER_Y  = 32'd15728640;
	localparam logic [12:0] RST_WIDTH     = 13'd640;
	localparam logic [12:0] RST_HEIGHT    = 13'd480;
	localparam logic [6:0]  RST_DOWNSCALE = 7'd4;
	localparam logic [31:0] RST_TOLERANCE = 32'd65536;

	localparam logic [3:0]  POSE_WORDS = 4'd12;
	localparam logic [31:0] FAR_DEPTH  = 32'hFFFF_FFFF;

	// Item class decided in the front end
	typedef enum logic [1:0] {
		K_POSE  = 2'd0,
		K_DEPTH = 2'd1,
		K_VIS   = 2'd2,
		K_NOP   = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic        pose_ok;
		logic [3:0]  pose_index;
		logic [31:0] pose_value;
		logic [31:0] voxel_x;
		logic [31:0] voxel_y;
		logic [31:0] voxel_z;
	} item_t;

	typedef struct packed {
		logic [31:0] focal_x;
		logic [31:0] focal_y;
		logic [31:0] center_x;
		logic [31:0] center_y;
		logic [12:0] image_width;
		logic [12:0] image_height;
		logic [6:0]  downscale;
		logic [31:0] depth_tolerance;
	} cfg_t;

	typedef struct packed {
		logic        in_view;
		logic        visible;
		logic [14:0] cell_index;
		logic [31:0] camera_depth;
	} result_t;

endpackage

`default_nettype wire

@@ hdl/voxel_zbuffer_visibility_unit.sv @@
// Top level of the voxel z-buffer visibility block: configuration registers,
// front-end queue and back-end sequencer. Depends on vzb_pkg, vzb_front, vzb_back.
//
// Channel   Direction  Handshake          Payload
// input     in         push / full        func, pose_index, pose_value, voxel_x/y/z
// result    out        empty / pop        in_view, visible, cell_index, camera_depth
// config    in         cfg_valid / ready  cfg_index, cfg_data
//
// Pose loads and unused codes go from idle straight to the result slot. A voxel needs
// nine transform products on one shared multiplier, then five divisions (u, v,
// column, row, grid width) on one 64-bit divider at one quotient bit per cycle.
// After reset and after each load of pose word 0 the z-buffer is cleared, one cell
// per cycle over all MAX_CELLS cells, and no item enters the back end meanwhile.
// Two input items queue while the back end works; a finished result waits in its
// slot while the next item proceeds. cfg_ready is always high.
`default_nettype none

module voxel_zbuffer_visibility_unit #(
	parameter int MAX_CELLS = 32768
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [1:0]  func,
	input  wire logic [3:0]  pose_index,
	input  wire logic [31:0] pose_value,
	input  wire logic [31:0] voxel_x,
	input  wire logic [31:0] voxel_y,
	input  wire logic [31:0] voxel_z,
	output logic             empty,
	input  wire logic        pop,
	output logic             in_view,
	output logic             visible,
	output logic [14:0]      cell_index,
	output logic [31:0]      camera_depth,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	vzb_pkg::cfg_t    cfg_q;
	vzb_pkg::item_t   q_item;
	vzb_pkg::result_t res;
	logic             q_valid;
	logic             q_pop;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.focal_x         <= vzb_pkg::RST_FOCAL_X;
			cfg_q.focal_y         <= vzb_pkg::RST_FOCAL_Y;
			cfg_q.center_x        <= vzb_pkg::RST_CENTER_X;
			cfg_q.center_y        <= vzb_pkg::RST_CENTER_Y;
			cfg_q.image_width     <= vzb_pkg::RST_WIDTH;
			cfg_q.image_height    <= vzb_pkg::RST_HEIGHT;
			cfg_q.downscale       <= vzb_pkg::RST_DOWNSCALE;
			cfg_q.depth_tolerance <= vzb_pkg::RST_TOLERANCE;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				vzb_pkg::REG_FOCAL_X:   cfg_q.focal_x         <= cfg_data;
				vzb_pkg::REG_FOCAL_Y:   cfg_q.focal_y         <= cfg_data;
				vzb_pkg::REG_CENTER_X:  cfg_q.center_x        <= cfg_data;
				vzb_pkg::REG_CENTER_Y:  cfg_q.center_y        <= cfg_data;
				vzb_pkg::REG_WIDTH:     cfg_q.image_width     <= cfg_data[12:0];
				vzb_pkg::REG_HEIGHT:    cfg_q.image_height    <= cfg_data[12:0];
				vzb_pkg::REG_DOWNSCALE: cfg_q.downscale       <= cfg_data[6:0];
				vzb_pkg::REG_TOLERANCE: cfg_q.depth_tolerance <= cfg_data;
				default:                cfg_q.focal_x         <= cfg_q.focal_x;
			endcase
		end
	end

	vzb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.func       (func),
		.pose_index (pose_index),
		.pose_value (pose_value),
		.voxel_x    (voxel_x),
		.voxel_y    (voxel_y),
		.voxel_z    (voxel_z),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.q_pop      (q_pop)
	);

	vzb_back #(
		.MAX_CELLS(MAX_CELLS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.res_pop   (pop),
		.res_empty (empty),
		.res       (res)
	);

	assign in_view      = res.in_view;
	assign visible      = res.visible;
	assign cell_index   = res.cell_index;
	assign camera_depth = res.camera_depth;

endmodule

`default_nettype wire

@@ hdl/vzb_front.sv @@
// Front end: input item queue and item classification.
// Depends on vzb_pkg.
`default_nettype none

module vzb_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire logic [1:0]         func,
	input  wire logic [3:0]         pose_index,
	input  wire logic [31:0]        pose_value,
	input  wire logic [31:0]        voxel_x,
	input  wire logic [31:0]        voxel_y,
	input  wire logic [31:0]        voxel_z,
	output logic                    q_valid,
	output vzb_pkg::item_t          q_item,
	input  wire logic               q_pop
);

	vzb_pkg::item_t item_c;
	vzb_pkg::item_t fifo_q [2];
	logic           wr_q;
	logic           rd_q;
	logic [1:0]     cnt_q;
	logic           push_ok;

	// Classify the incoming item
	always_comb begin
		item_c = '0;
		unique case (func)
			vzb_pkg::FUNC_POSE:  item_c.kind = vzb_pkg::K_POSE;
			vzb_pkg::FUNC_DEPTH: item_c.kind = vzb_pkg::K_DEPTH;
			vzb_pkg::FUNC_VIS:   item_c.kind = vzb_pkg::K_VIS;
			default:             item_c.kind = vzb_pkg::K_NOP;
		endcase
		item_c.pose_ok    = pose_index < vzb_pkg::POSE_WORDS;
		item_c.pose_index = pose_index;
		item_c.pose_value = pose_value;
		item_c.voxel_x    = voxel_x;
		item_c.voxel_y    = voxel_y;
		item_c.voxel_z    = voxel_z;
	end

	assign full    = cnt_q == 2'd2;
	assign push_ok = push && !full;
	assign q_valid = cnt_q != 2'd0;
	assign q_item  = fifo_q[rd_q];

	// Two-entry queue toward the back end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push_ok) begin
				wr_q <= ~wr_q;
			end
			if (q_pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push_ok} - {1'b0, q_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push_ok) begin
			fifo_q[wr_q] <= item_c;
		end
	end

endmodule

`default_nettype wire

@@ hdl/vzb_div.sv @@
// Iterative restoring divider, one quotient bit per cycle.
// Depends on nothing; used by vzb_back for projection and cell mapping.
`default_nettype none

module vzb_div #(
	parameter int NW = 64,
	parameter int DW = 32
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	output logic               done,
	output logic [NW-1:0]      quot,
	output logic               rem_nz
);

	localparam int CW = (NW > 1) ? $clog2(NW) : 1;

	logic [NW-1:0] q_q;
	logic [DW-1:0] r_q;
	logic [DW-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW:0]   shift_c;
	logic [DW:0]   diff_c;
	logic          ge_c;

	// One shift-subtract step
	assign shift_c = {r_q, q_q[NW-1]};
	assign ge_c    = shift_c >= {1'b0, den_q};
	assign diff_c  = shift_c - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			q_q    <= '0;
			r_q    <= '0;
			den_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				q_q    <= num;
				r_q    <= '0;
				den_q  <= den;
			end else if (busy_q) begin
				q_q   <= {q_q[NW-2:0], ge_c};
				r_q   <= ge_c ? diff_c[DW-1:0] : shift_c[DW-1:0];
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done   = done_q;
	assign quot   = q_q;
	assign rem_nz = |r_q;

endmodule

`default_nettype wire

@@ hdl/vzb_back.sv @@
// Back end: pose store, camera transform, projection, z-buffer and result slot.
// Depends on vzb_pkg and vzb_div.
`default_nettype none

module vzb_back #(
	parameter int MAX_CELLS = 32768
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire vzb_pkg::cfg_t   cfg,
	input  wire logic            q_valid,
	input  wire vzb_pkg::item_t  q_item,
	output logic                 q_pop,
	input  wire logic            res_pop,
	output logic                 res_empty,
	output vzb_pkg::result_t     res
);

	localparam int AW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
	localparam logic signed [65:0] QLIM   = 66'sd1099511627776;
	localparam logic signed [51:0] SAT_HI = 52'sd2147483647;
	localparam logic signed [51:0] SAT_LO = -52'sd2147483648;

	// Divider operand selects
	localparam logic [2:0] D_U   = 3'd0;
	localparam logic [2:0] D_V   = 3'd1;
	localparam logic [2:0] D_COL = 3'd2;
	localparam logic [2:0] D_ROW = 3'd3;
	localparam logic [2:0] D_WC  = 3'd4;

	typedef enum logic [10:0] {
		ST_IDLE  = 11'b000_0000_0001,
		ST_CLEAR = 11'b000_0000_0010,
		ST_MUL   = 11'b000_0000_0100,
		ST_PMUL  = 11'b000_0000_1000,
		ST_DIVS  = 11'b000_0001_0000,
		ST_DIVW  = 11'b000_0010_0000,
		ST_CHK   = 11'b000_0100_0000,
		ST_CELL  = 11'b000_1000_0000,
		ST_LOOK  = 11'b001_0000_0000,
		ST_CMP   = 11'b010_0000_0000,
		ST_DONE  = 11'b100_0000_0000
	} st_t;

	st_t                  state_q;
	vzb_pkg::kind_t       kind_q;
	logic [31:0]          pose_q [12];
	logic signed [32:0]   d_q [3];
	logic [3:0]           step_q;
	logic signed [64:0]   prod_s1;
	logic [1:0]           pj_s1;
	logic [1:0]           pk_s1;
	logic                 pvld_s1;
	logic signed [51:0]   acc_q;
	logic signed [31:0]   cam_q [3];
	logic signed [64:0]   pprod_q;
	logic [2:0]           dsel_q;
	logic signed [43:0]   u_q;
	logic signed [43:0]   v_q;
	logic [13:0]          col_q;
	logic [13:0]          row_q;
	logic [13:0]          wc_q;
	logic [28:0]          cell_q;
	logic                 clear_pend_q;
	logic [AW-1:0]        clr_q;
	vzb_pkg::result_t     pend_q;
	vzb_pkg::result_t     res_q;
	logic                 res_valid_q;
	logic [31:0]          zbuf_q [MAX_CELLS];
	logic [31:0]          rd_q;

	logic [3:0]           jk_c;
	logic [1:0]           j_c;
	logic [1:0]           k_c;
	logic [3:0]           ridx_c;
	logic signed [64:0]   mul_c;
	logic signed [48:0]   flr_c;
	logic signed [51:0]   acc_c;
	logic [31:0]          sat_c;
	logic signed [31:0]   pa_c;
	logic [31:0]          pf_c;
	logic signed [64:0]   pm_c;
	logic signed [64:0]   mag_c;
	logic [6:0]           scale_c;
	logic [63:0]          div_num_c;
	logic [31:0]          div_den_c;
	logic                 div_start;
	logic                 div_done;
	logic [63:0]          div_quot;
	logic                 div_rnz;
	logic signed [65:0]   qs_c;
	logic signed [41:0]   qc_c;
	logic [31:0]          c_sel_c;
	logic signed [43:0]   pix_c;
	logic                 inside_c;
	logic                 vis_c;
	logic                 res_load;
	logic                 mem_we;
	logic [AW-1:0]        mem_waddr;
	logic [31:0]          mem_wdata;
	logic                 mem_re;
	vzb_pkg::result_t     miss_c;

	// Step order of the 3x3 transform: column j outer, row k inner
	function automatic logic [3:0] step_jk(input logic [3:0] s);
		logic [3:0] r;
		case (s)
			4'd0:    r = {2'd0, 2'd0};
			4'd1:    r = {2'd0, 2'd1};
			4'd2:    r = {2'd0, 2'd2};
			4'd3:    r = {2'd1, 2'd0};
			4'd4:    r = {2'd1, 2'd1};
			4'd5:    r = {2'd1, 2'd2};
			4'd6:    r = {2'd2, 2'd0};
			4'd7:    r = {2'd2, 2'd1};
			4'd8:    r = {2'd2, 2'd2};
			default: r = 4'd0;
		endcase
		return r;
	endfunction

	// Transform multiply and accumulate
	assign jk_c   = step_jk(step_q);
	assign j_c    = jk_c[3:2];
	assign k_c    = jk_c[1:0];
	assign ridx_c = 4'({2'b0, k_c} * 4'd3) + {2'b0, j_c};
	assign mul_c  = d_q[k_c] * $signed(pose_q[ridx_c]);
	assign flr_c  = prod_s1[64:16];
	assign acc_c  = ((pk_s1 == 2'd0) ? 52'sd0 : acc_q) + {{3{flr_c[48]}}, flr_c};

	always_comb begin
		if (acc_c > SAT_HI) begin
			sat_c = 32'h7FFF_FFFF;
		end else if (acc_c < SAT_LO) begin
			sat_c = 32'h8000_0000;
		end else begin
			sat_c = acc_c[31:0];
		end
	end

	// Projection product a * f
	assign pa_c = (dsel_q == D_U) ? cam_q[0] : cam_q[1];
	assign pf_c = (dsel_q == D_U) ? cfg.focal_x : cfg.focal_y;
	assign pm_c = pa_c * $signed({1'b0, pf_c});
	assign mag_c = pprod_q[64] ? -pprod_q : pprod_q;

	// Divider operands
	assign scale_c = (cfg.downscale == 7'd0) ? 7'd1 : cfg.downscale;
	always_comb begin
		unique case (dsel_q)
			D_U, D_V: begin
				div_num_c = mag_c[63:0];
				div_den_c = cam_q[2];
			end
			D_COL: begin
				div_num_c = {51'b0, u_q[28:16]};
				div_den_c = {25'b0, scale_c};
			end
			D_ROW: begin
				div_num_c = {51'b0, v_q[28:16]};
				div_den_c = {25'b0, scale_c};
			end
			default: begin
				div_num_c = {50'b0, 14'(cfg.image_width) + 14'(scale_c) - 14'd1};
				div_den_c = {25'b0, scale_c};
			end
		endcase
	end

	assign div_start = state_q == ST_DIVS;

	vzb_div #(
		.NW(64),
		.DW(32)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num_c),
		.den    (div_den_c),
		.done   (div_done),
		.quot   (div_quot),
		.rem_nz (div_rnz)
	);

	// Floored quotient, clamp, add principal point
	always_comb begin
		if (pprod_q[64]) begin
			qs_c = -$signed({2'b0, div_quot}) - $signed({65'b0, div_rnz});
		end else begin
			qs_c = $signed({2'b0, div_quot});
		end
		if (qs_c > QLIM) begin
			qc_c = QLIM[41:0];
		end else if (qs_c < -QLIM) begin
			qc_c = 42'(-QLIM);
		end else begin
			qc_c = qs_c[41:0];
		end
		c_sel_c = (dsel_q == D_U) ? cfg.center_x : cfg.center_y;
		pix_c   = {{2{qc_c[41]}}, qc_c} + $signed({12'b0, c_sel_c});
	end

	assign inside_c = !u_q[43] && !v_q[43] &&
		($unsigned(u_q) < {15'b0, cfg.image_width, 16'b0}) &&
		($unsigned(v_q) < {15'b0, cfg.image_height, 16'b0});

	assign vis_c = (kind_q == vzb_pkg::K_VIS) &&
		({1'b0, cam_q[2]} <= ({1'b0, rd_q} + {1'b0, cfg.depth_tolerance}));

	always_comb begin
		miss_c              = '0;
		miss_c.camera_depth = cam_q[2];
	end

	// Z-buffer port control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cell_q[AW-1:0];
		mem_wdata = cam_q[2];
		if (state_q == ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
			mem_wdata = vzb_pkg::FAR_DEPTH;
		end else if (state_q == ST_CMP && kind_q == vzb_pkg::K_DEPTH &&
			($unsigned(cam_q[2]) < rd_q)) begin
			mem_we = 1'b1;
		end
	end

	assign mem_re = (state_q == ST_LOOK) && (cell_q < 29'(MAX_CELLS));

	always_ff @(posedge clk) begin
		if (mem_we) begin
			zbuf_q[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_q <= zbuf_q[cell_q[AW-1:0]];
		end
	end

	assign q_pop    = (state_q == ST_IDLE) && q_valid;
	assign res_load = (state_q == ST_DONE) && (!res_valid_q || res_pop);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			kind_q       <= vzb_pkg::K_NOP;
			for (int i = 0; i < 12; i++) begin
				pose_q[i] <= '0;
			end
			for (int i = 0; i < 3; i++) begin
				d_q[i]   <= '0;
				cam_q[i] <= '0;
			end
			step_q       <= '0;
			prod_s1      <= '0;
			pj_s1        <= '0;
			pk_s1        <= '0;
			pvld_s1      <= 1'b0;
			acc_q        <= '0;
			pprod_q      <= '0;
			dsel_q       <= D_U;
			u_q          <= '0;
			v_q          <= '0;
			col_q        <= '0;
			row_q        <= '0;
			wc_q         <= '0;
			cell_q       <= '0;
			clear_pend_q <= 1'b0;
			clr_q        <= '0;
			pend_q       <= '0;
			res_q        <= '0;
			res_valid_q  <= 1'b0;
		end else begin
			res_valid_q <= res_load || (res_valid_q && !res_pop);
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						kind_q <= q_item.kind;
						unique case (q_item.kind)
							vzb_pkg::K_POSE: begin
								if (q_item.pose_ok) begin
									pose_q[q_item.pose_index] <= q_item.pose_value;
								end
								clear_pend_q <= q_item.pose_ok && (q_item.pose_index == 4'd0);
								pend_q  <= '0;
								state_q <= ST_DONE;
							end
							vzb_pkg::K_NOP: begin
								pend_q  <= '0;
								state_q <= ST_DONE;
							end
							default: begin
								d_q[0]  <= $signed({q_item.voxel_x[31], q_item.voxel_x}) -
									$signed({pose_q[9][31], pose_q[9]});
								d_q[1]  <= $signed({q_item.voxel_y[31], q_item.voxel_y}) -
									$signed({pose_q[10][31], pose_q[10]});
								d_q[2]  <= $signed({q_item.voxel_z[31], q_item.voxel_z}) -
									$signed({pose_q[11][31], pose_q[11]});
								step_q  <= '0;
								pvld_s1 <= 1'b0;
								state_q <= ST_MUL;
							end
						endcase
					end
				end
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(MAX_CELLS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_MUL: begin
					if (step_q < 4'd9) begin
						prod_s1 <= mul_c;
						pj_s1   <= j_c;
						pk_s1   <= k_c;
					end
					pvld_s1 <= step_q < 4'd9;
					if (pvld_s1) begin
						acc_q <= acc_c;
						if (pk_s1 == 2'd2) begin
							cam_q[pj_s1] <= sat_c;
						end
					end
					step_q <= step_q + 4'd1;
					if (step_q == 4'd9) begin
						dsel_q  <= D_U;
						state_q <= ST_PMUL;
					end
				end
				ST_PMUL: begin
					if (cam_q[2] <= 32'sd0) begin
						pend_q  <= miss_c;
						state_q <= ST_DONE;
					end else begin
						pprod_q <= pm_c;
						state_q <= ST_DIVS;
					end
				end
				ST_DIVS: begin
					state_q <= ST_DIVW;
				end
				ST_DIVW: begin
					if (div_done) begin
						unique case (dsel_q)
							D_U: begin
								u_q     <= pix_c;
								dsel_q  <= D_V;
								state_q <= ST_PMUL;
							end
							D_V: begin
								v_q     <= pix_c;
								state_q <= ST_CHK;
							end
							D_COL: begin
								col_q   <= div_quot[13:0];
								dsel_q  <= D_ROW;
								state_q <= ST_DIVS;
							end
							D_ROW: begin
								row_q   <= div_quot[13:0];
								dsel_q  <= D_WC;
								state_q <= ST_DIVS;
							end
							default: begin
								wc_q    <= div_quot[13:0];
								state_q <= ST_CELL;
							end
						endcase
					end
				end
				ST_CHK: begin
					if (inside_c) begin
						dsel_q  <= D_COL;
						state_q <= ST_DIVS;
					end else begin
						pend_q  <= miss_c;
						state_q <= ST_DONE;
					end
				end
				ST_CELL: begin
					cell_q  <= 29'(row_q) * 29'(wc_q) + 29'(col_q);
					state_q <= ST_LOOK;
				end
				ST_LOOK: begin
					if (cell_q < 29'(MAX_CELLS)) begin
						state_q <= ST_CMP;
					end else begin
						pend_q  <= miss_c;
						state_q <= ST_DONE;
					end
				end
				ST_CMP: begin
					pend_q.in_view      <= 1'b1;
					pend_q.visible      <= vis_c;
					pend_q.cell_index   <= cell_q[14:0];
					pend_q.camera_depth <= cam_q[2];
					state_q             <= ST_DONE;
				end
				ST_DONE: begin
					if (res_load) begin
						res_q        <= pend_q;
						clr_q        <= '0;
						clear_pend_q <= 1'b0;
						state_q      <= clear_pend_q ? ST_CLEAR : ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign res_empty = !res_valid_q;
	assign res       = res_q;

endmodule

`default_nettype wire

@@ hdl/vzb_checker.sv @@
// Port-level checks of the visibility block's result channel, bound to the top level.
// Depends on assert_macros.svh and voxel_zbuffer_visibility_unit.
`default_nettype none
`include "assert_macros.svh"

module vzb_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        empty,
	input wire logic        pop,
	input wire logic        in_view,
	input wire logic        visible,
	input wire logic [14:0] cell_index,
	input wire logic [31:0] camera_depth
);

	// A waiting result that is not taken stays put
	`VZB_ASSERT_NEXT(a_res_hold, !empty && !pop, !empty && $stable(in_view) && $stable(visible) && $stable(cell_index) && $stable(camera_depth), "result changed while stalled")

	// Visible only for voxels that are in view
	`VZB_ASSERT_IMPL(a_vis_in_view, !empty && visible, in_view, "visible without in_view")

	// Cells outside the view report index zero
	`VZB_ASSERT_IMPL(a_cell_zero, !empty && !in_view, cell_index == 15'd0, "cell index set while not in view")

	// In-view voxels have positive depth
	`VZB_ASSERT_IMPL(a_depth_pos, !empty && in_view, !camera_depth[31] && (camera_depth != 32'd0), "in view with non-positive depth")

endmodule

bind voxel_zbuffer_visibility_unit vzb_checker u_vzb_checker (.*);

`default_nettype wire

@@ tb/sv/tb_voxel_zbuffer_visibility_unit.sv @@
// Testbench for voxel_zbuffer_visibility_unit: transform, projection, z-buffer min and
// visibility test against a built-in predictor. Depends on vzb_pkg and the block RTL.
`timescale 1ns / 1ps

module tb_voxel_zbuffer_visibility_unit;

	localparam int NCELLS = 32768;
	localparam int STALL_LIMIT = 100000;
	localparam int DRAIN_CYCLES = 400;
	localparam int HOLD_CYCLES = 3000;
	localparam longint QCLAMP = 64'sd1099511627776;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	logic [1:0] func = '0;
	logic [3:0] pose_index = '0;
	logic [31:0] pose_value = '0, voxel_x = '0, voxel_y = '0, voxel_z = '0;
	logic empty;
	logic pop = 1'b0;
	logic in_view, visible;
	logic [14:0] cell_index;
	logic [31:0] camera_depth;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	voxel_zbuffer_visibility_unit uut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Predictor state
	logic [31:0] fx_r, fy_r, cx_r, cy_r, tol_r;
	logic [12:0] wid_r, hgt_r;
	logic [6:0]  ds_r;
	logic [31:0] pose_w [12];
	logic [31:0] zmin_cells [NCELLS];
	vzb_pkg::result_t expected_views [$];

	int errors = 0;
	bit quiet = 1'b0;
	bit hold_go = 1'b0;

	// Camera used for generating well-formed voxels
	longint cam_t [3];
	int cam_sgn [3];
	int ray_x [16], ray_y [16];
	logic [31:0] vox_list [$][3];

	task automatic report(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	function automatic longint to_s(input logic [31:0] w);
		return longint'(signed'(w));
	endfunction

	function automatic longint proj_axis(input longint a, input logic [31:0] f,
			input logic [31:0] c, input longint z);
		longint n, q;
		n = a * longint'(f);
		q = n / z;
		if ((n % z) != 0 && n < 0)
			q--;
		if (q > QCLAMP)
			q = QCLAMP;
		if (q < -QCLAMP)
			q = -QCLAMP;
		return q + longint'(c);
	endfunction

	// Works out the result of one item and updates pose and z-buffer state
	function automatic vzb_pkg::result_t project_voxel(input logic [1:0] f,
			input logic [3:0] pi, input logic [31:0] pv, input logic [31:0] vx,
			input logic [31:0] vy, input logic [31:0] vz);
		longint d [3], cam [3];
		longint acc, u, v;
		longint unsigned s, wc, cell_n;
		logic [31:0] p [3];
		logic ok, vis;
		vzb_pkg::result_t r;
		r = '0;
		p[0] = vx; p[1] = vy; p[2] = vz;
		ok = 1'b0; vis = 1'b0; cell_n = 0;
		if (f == vzb_pkg::FUNC_POSE) begin
			if (pi < vzb_pkg::POSE_WORDS) begin
				pose_w[pi] = pv;
				if (pi == 4'd0)
					foreach (zmin_cells[i]) zmin_cells[i] = vzb_pkg::FAR_DEPTH;
			end
			return r;
		end
		if (vzb_pkg::kind_t'(f) == vzb_pkg::K_NOP)
			return r;
		for (int k = 0; k < 3; k++)
			d[k] = to_s(p[k]) - to_s(pose_w[9 + k]);
		for (int j = 0; j < 3; j++) begin
			acc = 0;
			for (int k = 0; k < 3; k++)
				acc += (d[k] * to_s(pose_w[k * 3 + j])) >>> 16;
			if (acc > 64'sd2147483647)
				acc = 64'sd2147483647;
			if (acc < -64'sd2147483648)
				acc = -64'sd2147483648;
			cam[j] = acc;
		end
		if (cam[2] > 0) begin
			u = proj_axis(cam[0], fx_r, cx_r, cam[2]);
			v = proj_axis(cam[1], fy_r, cy_r, cam[2]);
			if (u >= 0 && v >= 0 && u < (longint'(wid_r) <<< 16)
					&& v < (longint'(hgt_r) <<< 16)) begin
				s = (ds_r == 0) ? 1 : ds_r;
				wc = (longint'(wid_r) + s - 1) / s;
				cell_n = ((longint'(v) >> 16) / s) * wc + (longint'(u) >> 16) / s;
				ok = cell_n < NCELLS;
			end
		end
		if (ok) begin
			if (f == vzb_pkg::FUNC_DEPTH) begin
				if (cam[2] < longint'(zmin_cells[cell_n]))
					zmin_cells[cell_n] = cam[2][31:0];
			end else begin
				vis = cam[2] <= longint'(zmin_cells[cell_n]) + longint'(tol_r);
			end
		end else begin
			cell_n = 0;
		end
		r.in_view = ok;
		r.visible = vis;
		r.cell_index = cell_n[14:0];
		r.camera_depth = cam[2][31:0];
		return r;
	endfunction

	// Sends one item; called and returning at a falling edge
	task automatic push_item(input logic [1:0] f, input logic [3:0] pi, input logic [31:0] pv,
			input logic [31:0] vx, input logic [31:0] vy, input logic [31:0] vz);
		if (!quiet && $urandom_range(99) < 10) begin
			push = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		push = 1'b1;
		func = f; pose_index = pi; pose_value = pv;
		voxel_x = vx; voxel_y = vy; voxel_z = vz;
		@(posedge clk);
		while (full) @(posedge clk);
		expected_views.push_back(project_voxel(f, pi, pv, vx, vy, vz));
		@(negedge clk);
	endtask

	task automatic wait_idle();
		push = 1'b0;
		wait (expected_views.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		cfg_valid = 1'b1; cfg_index = idx; cfg_data = val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			vzb_pkg::REG_FOCAL_X:   fx_r = val;
			vzb_pkg::REG_FOCAL_Y:   fy_r = val;
			vzb_pkg::REG_CENTER_X:  cx_r = val;
			vzb_pkg::REG_CENTER_Y:  cy_r = val;
			vzb_pkg::REG_WIDTH:     wid_r = val[12:0];
			vzb_pkg::REG_HEIGHT:    hgt_r = val[12:0];
			vzb_pkg::REG_DOWNSCALE: ds_r = val[6:0];
			default:                tol_r = val;
		endcase
		@(negedge clk);
	endtask

	// Writes every register, only once the block has drained
	task automatic set_config(input logic [31:0] fx, input logic [31:0] fy,
			input logic [31:0] cx, input logic [31:0] cy, input logic [31:0] w,
			input logic [31:0] h, input logic [31:0] ds, input logic [31:0] tol);
		wait_idle();
		write_reg(vzb_pkg::REG_FOCAL_X, fx);
		write_reg(vzb_pkg::REG_FOCAL_Y, fy);
		write_reg(vzb_pkg::REG_CENTER_X, cx);
		write_reg(vzb_pkg::REG_CENTER_Y, cy);
		write_reg(vzb_pkg::REG_WIDTH, w);
		write_reg(vzb_pkg::REG_HEIGHT, h);
		write_reg(vzb_pkg::REG_DOWNSCALE, ds);
		write_reg(vzb_pkg::REG_TOLERANCE, tol);
		cfg_valid = 1'b0;
	endtask

	// Loads a diagonal +-1 rotation (optionally perturbed) and a translation
	task automatic load_camera(input bit perturb);
		logic [31:0] w;
		for (int k = 0; k < 3; k++) begin
			cam_sgn[k] = (k == 1 || $urandom_range(1)) ? 1 : -1;
			cam_t[k] = longint'($urandom_range(0, 20 << 16)) - (10 << 16);
		end
		cam_sgn[2] = cam_sgn[0] * cam_sgn[1] == 1 ? 1 : cam_sgn[2];
		for (int i = 0; i < 9; i++) begin
			w = (i % 4 == 0) ? 32'(cam_sgn[i / 4] * 65536) : 32'd0;
			if (perturb)
				w = w + 32'($urandom_range(0, 8192)) - 32'd4096;
			push_item(vzb_pkg::FUNC_POSE, 4'(i), w, '0, '0, '0);
		end
		for (int k = 0; k < 3; k++)
			push_item(vzb_pkg::FUNC_POSE, 4'(9 + k), cam_t[k][31:0], '0, '0, '0);
		foreach (ray_x[i]) begin
			ray_x[i] = $urandom_range(0, 40000) - 20000;
			ray_y[i] = $urandom_range(0, 30000) - 15000;
		end
	endtask

	// Well-formed voxel: along one of a few rays, so that cells are shared
	task automatic make_voxel(output logic [31:0] p [3]);
		longint c [3];
		int r;
		r = $urandom_range(15);
		c[2] = longint'($urandom_range(1 << 15, 30 << 16));
		c[0] = (c[2] * ray_x[r]) >>> 16;
		c[1] = (c[2] * ray_y[r]) >>> 16;
		for (int k = 0; k < 3; k++)
			p[k] = 32'(cam_t[k] + cam_sgn[k] * c[k]);
	endtask

	task automatic test_directed();
		logic [31:0] p [3];
		load_camera(1'b0);
		push_item(vzb_pkg::FUNC_POSE, 4'd12, 32'h8000_0000, '0, '0, '0);
		push_item(vzb_pkg::FUNC_POSE, 4'd15, 32'h7FFF_FFFF, '0, '0, '0);
		push_item(2'd3, 4'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		// Visibility before any depth, near and far depth on the same ray, then visibility of both and of a nearer voxel
		p[0] = 32'(cam_t[0]); p[1] = 32'(cam_t[1]);
		p[2] = 32'(cam_t[2] + cam_sgn[2] * (5 << 16));
		push_item(vzb_pkg::FUNC_VIS, '0, '0, p[0], p[1], p[2]);
		push_item(vzb_pkg::FUNC_DEPTH, '0, '0, p[0], p[1], p[2]);
		push_item(vzb_pkg::FUNC_DEPTH, '0, '0, p[0], p[1],
			32'(cam_t[2] + cam_sgn[2] * (9 << 16)));
		push_item(vzb_pkg::FUNC_VIS, '0, '0, p[0], p[1], p[2]);
		push_item(vzb_pkg::FUNC_VIS, '0, '0, p[0], p[1],
			32'(cam_t[2] + cam_sgn[2] * (9 << 16)));
		push_item(vzb_pkg::FUNC_VIS, '0, '0, p[0], p[1],
			32'(cam_t[2] + cam_sgn[2] * 6 * 65536 / 5));
		// Behind the camera, off the image edge, saturating extremes
		push_item(vzb_pkg::FUNC_DEPTH, '0, '0, p[0], p[1],
			32'(cam_t[2] - cam_sgn[2] * (3 << 16)));
		push_item(vzb_pkg::FUNC_DEPTH, '0, '0, 32'(cam_t[0] + (50 << 16)), p[1], p[2]);
		push_item(vzb_pkg::FUNC_DEPTH, '0, '0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
		push_item(vzb_pkg::FUNC_VIS, '0, '0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
		push_item(vzb_pkg::FUNC_DEPTH, '0, '0, '0, '0, '0);
	endtask

	task automatic test_config_extremes();
		logic [31:0] p [3];
		p[0] = 32'(cam_t[0]); p[1] = 32'(cam_t[1]);
		p[2] = 32'(cam_t[2] + cam_sgn[2] * (7 << 16));
		// Zero-size image: nothing in view
		set_config(32'hFFFF_FFFF, 32'd0, 32'd0, 32'hFFFF_FFFF, 0, 0, 0, 32'd0);
		push_item(vzb_pkg::FUNC_DEPTH, '0, '0, p[0], p[1], p[2]);
		push_item(vzb_pkg::FUNC_VIS, '0, '0, p[0], p[1], p[2]);
		// Large image with unit cells: centre row lands beyond the cell store
		set_config(32'd1 << 16, 32'd1 << 16, 32'd2048 << 16, 32'd2048 << 16,
			4096, 4096, 1, 32'hFFFF_FFFF);
		push_item(vzb_pkg::FUNC_DEPTH, '0, '0, p[0], p[1], p[2]);
		push_item(vzb_pkg::FUNC_VIS, '0, '0, p[0], p[1], p[2]);
		// Centre near the top left, zero downscale counts as one
		set_config(32'd4 << 16, 32'd4 << 16, 32'd3 << 16, 32'd2 << 16, 8191, 8191, 0, 0);
		push_item(vzb_pkg::FUNC_DEPTH, '0, '0, p[0], p[1], p[2]);
		push_item(vzb_pkg::FUNC_VIS, '0, '0, p[0], p[1], p[2]);
		// Widest cells
		set_config(32'd100 << 16, 32'd100 << 16, 32'd64 << 16, 32'd64 << 16, 128, 128, 127, 0);
		push_item(vzb_pkg::FUNC_DEPTH, '0, '0, p[0], p[1], p[2]);
		push_item(vzb_pkg::FUNC_VIS, '0, '0, p[0], p[1], p[2]);
	endtask

	task automatic test_random_cameras(input int n_cam, input int n_vox);
		logic [31:0] p [3];
		int w, h;
		for (int c = 0; c < n_cam; c++) begin
			w = $urandom_range(16, 640);
			h = $urandom_range(12, 480);
			case (c)
				0: set_config(vzb_pkg::RST_FOCAL_X, vzb_pkg::RST_FOCAL_Y,
					vzb_pkg::RST_CENTER_X, vzb_pkg::RST_CENTER_Y,
					32'(vzb_pkg::RST_WIDTH), 32'(vzb_pkg::RST_HEIGHT),
					32'(vzb_pkg::RST_DOWNSCALE), vzb_pkg::RST_TOLERANCE);
				1: set_config(32'd200 << 16, 32'd200 << 16, w << 15, h << 15, w, h, 64, 0);
				default: set_config($urandom_range(50, 600) << 16,
					$urandom_range(50, 600) << 16,
					(w << 15) + $urandom_range(0, 65535), h << 15, w, h,
					$urandom_range(1, 16), $urandom_range(0, 4 << 16));
			endcase
			quiet = (c == 2);
			load_camera(c % 2);
			if (c == 3)
				hold_go = 1'b1;
			vox_list.delete();
			for (int i = 0; i < n_vox; i++) begin
				if ($urandom_range(9) == 0) begin
					// Noise: raw random fields, stray pose words, unused code
					case ($urandom_range(2))
						0: push_item(vzb_pkg::FUNC_POSE, 4'($urandom_range(1, 15)),
							$urandom, '0, '0, '0);
						1: push_item(2'd3, 4'($urandom), $urandom, $urandom, $urandom, $urandom);
						default: push_item(2'($urandom_range(1, 2)), 4'($urandom), $urandom,
							$urandom, $urandom, $urandom);
					endcase
				end else begin
					make_voxel(p);
					vox_list.push_back(p);
					push_item(vzb_pkg::FUNC_DEPTH, 4'($urandom), $urandom, p[0], p[1], p[2]);
				end
			end
			foreach (vox_list[i]) begin
				p = vox_list[i];
				push_item(vzb_pkg::FUNC_VIS, 4'($urandom), $urandom, p[0], p[1], p[2]);
			end
			quiet = 1'b0;
		end
	endtask

	// Result side: random pop, one long hold-off
	always @(negedge clk) begin
		if (hold_go) begin
			pop <= 1'b0;
			repeat (HOLD_CYCLES) @(negedge clk);
			hold_go = 1'b0;
		end else begin
			pop <= quiet || ($urandom_range(99) >= 10);
		end
	end

	// Result check against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (expected_views.size() == 0) begin
				report("unexpected item", camera_depth, 0);
			end else begin
				if (in_view !== expected_views[0].in_view)
					report("in_view", in_view, expected_views[0].in_view);
				if (visible !== expected_views[0].visible)
					report("visible", visible, expected_views[0].visible);
				if (cell_index !== expected_views[0].cell_index)
					report("cell_index", cell_index, expected_views[0].cell_index);
				if (camera_depth !== expected_views[0].camera_depth)
					report("camera_depth", camera_depth, expected_views[0].camera_depth);
				void'(expected_views.pop_front());
			end
		end
	end

	// Watchdog on cycles with no handshake at all
	int idle_cycles = 0;
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("voxel_zbuffer_visibility_unit regression: fail");
			$finish;
		end
	end

	initial begin
		fx_r = vzb_pkg::RST_FOCAL_X; fy_r = vzb_pkg::RST_FOCAL_Y;
		cx_r = vzb_pkg::RST_CENTER_X; cy_r = vzb_pkg::RST_CENTER_Y;
		wid_r = vzb_pkg::RST_WIDTH; hgt_r = vzb_pkg::RST_HEIGHT;
		ds_r = vzb_pkg::RST_DOWNSCALE; tol_r = vzb_pkg::RST_TOLERANCE;
		foreach (pose_w[i]) pose_w[i] = '0;
		foreach (zmin_cells[i]) zmin_cells[i] = vzb_pkg::FAR_DEPTH;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_config_extremes();
		test_random_cameras(6, 95);
		wait_idle();
		if (errors == 0 && expected_views.size() == 0)
			$display("voxel_zbuffer_visibility_unit regression: pass");
		else
			$display("voxel_zbuffer_visibility_unit regression: fail");
		$finish;
	end

endmodule
